>>> rtl/cbd_pkg.sv
// Shared types, constants and helpers for the chunked body deframer.
package cbd_pkg;

  localparam int SIZE_BITS_DEF  = 40;
  localparam int TOTAL_BITS_DEF = 32;

  localparam int LEN_W      = 32;
  localparam int LIMIT_W    = 32;
  localparam int DIGIT_BITS = 4;   // one hex digit, radix 16
  localparam int CFG_IDX_W  = 2;

  localparam logic [LIMIT_W-1:0] BODY_LIMIT_RST = LIMIT_W'(1024 * 1024);
  localparam logic               LIMIT_EN_RST   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = CFG_IDX_W'(1);

  // input beat kinds
  localparam logic [1:0] KIND_CHUNKED = 2'd0;
  localparam logic [1:0] KIND_FIXED   = 2'd1;
  localparam logic [1:0] KIND_BYTE    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_PAYLOAD   = 2'd0;
  localparam logic [1:0] ST_EMPTY_END = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  // characters
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;   // ';'
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HT   = 8'h09;
  localparam logic [7:0] CH_FF   = 8'h0C;

  localparam logic [1:0] SKIP_LEN = 2'd2;   // chunk separator bytes

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_FIXED = 7'b0000010,
    PH_SIZE  = 7'b0000100,
    PH_TRAIL = 7'b0001000,
    PH_CR    = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       digit_seen;
    logic       in_extension;
    logic       last_chunk_seen;
    logic [1:0] skip_count;
  } ctl_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] body_length;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       end_of_body;
  } out_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [DIGIT_BITS:0] hex_value(input logic [7:0] b);
    logic [DIGIT_BITS:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, DIGIT_BITS'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, DIGIT_BITS'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, DIGIT_BITS'(b - 8'h57)};
    return r;
  endfunction

  // space, tab, LF, VT, FF
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_HT && b <= CH_FF);
  endfunction

endpackage

>>> rtl/cbd_step.sv
// Next-state and result logic for one input beat of the deframer.
module cbd_step import cbd_pkg::*; #(
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  in_t                         item,
  input  logic [LIMIT_W-1:0]          body_limit,
  input  logic                        limit_enable,
  input  ctl_t                        ctl,
  input  logic [((SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W)-1:0] bytes_left,
  input  logic [SIZE_BITS-1:0]        size_accum,
  input  logic [TOTAL_BITS:0]         body_total,
  output ctl_t                        ctl_next,
  output logic [((SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W)-1:0] bytes_left_next,
  output logic [SIZE_BITS-1:0]        size_accum_next,
  output logic [TOTAL_BITS:0]         body_total_next,
  output logic                        res_valid,
  output out_t                        res
);

  localparam int LEFT_BITS = (SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W;
  localparam int WIDE_BITS = (SIZE_BITS > TOTAL_BITS + 1) ? SIZE_BITS : TOTAL_BITS + 1;
  localparam int SUM_W     = WIDE_BITS + 1;
  localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'({(TOTAL_BITS + 1){1'b1}});

  logic [SUM_W-1:0]      total_sum;
  logic [DIGIT_BITS:0]   hex;
  logic                  acc_ovf;
  phase_t                eff_phase;
  logic [LEFT_BITS-1:0]  left_dec;
  logic [1:0]            skip_dec;

  assign total_sum = SUM_W'(body_total) + SUM_W'(size_accum);
  assign hex       = hex_value(item.data_byte);
  assign acc_ovf   = |size_accum[SIZE_BITS-1 -: DIGIT_BITS];
  assign left_dec  = (bytes_left != '0) ? bytes_left - LEFT_BITS'(1) : bytes_left;
  assign skip_dec  = (ctl.skip_count != 2'd0) ? ctl.skip_count - 2'd1 : 2'd0;

  // a CR that is not followed by LF falls back into the size line
  always_comb begin
    eff_phase = ctl.phase;
    if (ctl.phase == PH_CR) begin
      eff_phase = (ctl.digit_seen && !ctl.in_extension) ? PH_TRAIL : PH_SIZE;
    end
  end

  always_comb begin
    ctl_next        = ctl;
    bytes_left_next = bytes_left;
    size_accum_next = size_accum;
    body_total_next = body_total;
    res_valid       = 1'b0;
    res             = '0;

    case (item.kind)
      KIND_CHUNKED: begin
        ctl_next.phase           = PH_SIZE;
        ctl_next.digit_seen      = 1'b0;
        ctl_next.in_extension    = 1'b0;
        ctl_next.last_chunk_seen = 1'b0;
        ctl_next.skip_count      = 2'd0;
        bytes_left_next          = '0;
        size_accum_next          = '0;
        body_total_next          = '0;
      end

      KIND_FIXED: begin
        ctl_next.digit_seen      = 1'b0;
        ctl_next.in_extension    = 1'b0;
        ctl_next.last_chunk_seen = 1'b0;
        ctl_next.skip_count      = 2'd0;
        bytes_left_next          = '0;
        size_accum_next          = '0;
        body_total_next          = '0;
        if (limit_enable && (item.body_length > body_limit)) begin
          ctl_next.phase = PH_IDLE;
          res_valid      = 1'b1;
          res.status     = ST_TOO_LARGE;
          res.end_of_body = 1'b1;
        end else if (item.body_length == '0) begin
          ctl_next.phase = PH_IDLE;
          res_valid      = 1'b1;
          res.status     = ST_EMPTY_END;
          res.end_of_body = 1'b1;
        end else begin
          ctl_next.phase  = PH_FIXED;
          bytes_left_next = LEFT_BITS'(item.body_length);
        end
      end

      KIND_BYTE: begin
        unique case (ctl.phase) inside
          PH_FIXED: begin
            bytes_left_next  = left_dec;
            res_valid        = 1'b1;
            res.payload_byte = item.data_byte;
            res.status       = ST_PAYLOAD;
            if (left_dec == '0) begin
              ctl_next.phase  = PH_IDLE;
              res.end_of_body = 1'b1;
            end
          end

          PH_SIZE, PH_TRAIL, PH_CR: begin
            if (ctl.phase == PH_CR && item.data_byte == CH_LF) begin
              // end of size line
              if (!ctl.digit_seen) begin
                ctl_next.phase  = PH_IDLE;
                res_valid       = 1'b1;
                res.status      = ST_MALFORMED;
                res.end_of_body = 1'b1;
              end else if (size_accum == '0) begin
                ctl_next.last_chunk_seen = 1'b1;
                ctl_next.skip_count      = SKIP_LEN;
                ctl_next.phase           = PH_SKIP;
              end else if (limit_enable && (total_sum > SUM_W'(body_limit))) begin
                ctl_next.phase  = PH_IDLE;
                res_valid       = 1'b1;
                res.status      = ST_TOO_LARGE;
                res.end_of_body = 1'b1;
              end else begin
                body_total_next = (total_sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_BITS:0]
                                                          : total_sum[TOTAL_BITS:0];
                bytes_left_next = LEFT_BITS'(size_accum);
                size_accum_next = '0;
                ctl_next.phase  = PH_DATA;
              end
            end else begin
              ctl_next.phase = eff_phase;
              if (item.data_byte == CH_CR) begin
                ctl_next.phase = PH_CR;
              end else if (ctl.in_extension) begin
                // extension text is skipped
              end else if (item.data_byte == CH_SEMI) begin
                ctl_next.in_extension = 1'b1;
              end else if (is_blank(item.data_byte)) begin
                if (ctl.digit_seen) ctl_next.phase = PH_TRAIL;
              end else if (!hex[DIGIT_BITS] || eff_phase == PH_TRAIL || acc_ovf) begin
                ctl_next.phase  = PH_IDLE;
                res_valid       = 1'b1;
                res.status      = ST_MALFORMED;
                res.end_of_body = 1'b1;
              end else begin
                size_accum_next = {size_accum[SIZE_BITS-DIGIT_BITS-1:0],
                                   hex[DIGIT_BITS-1:0]};
                ctl_next.digit_seen = 1'b1;
              end
            end
          end

          PH_DATA: begin
            bytes_left_next  = left_dec;
            res_valid        = 1'b1;
            res.payload_byte = item.data_byte;
            res.status       = ST_PAYLOAD;
            if (left_dec == '0) begin
              ctl_next.skip_count = SKIP_LEN;
              ctl_next.phase      = PH_SKIP;
            end
          end

          PH_SKIP: begin
            ctl_next.skip_count = skip_dec;
            if (skip_dec == 2'd0) begin
              if (ctl.last_chunk_seen) begin
                ctl_next.phase  = PH_IDLE;
                res_valid       = 1'b1;
                res.status      = ST_EMPTY_END;
                res.end_of_body = 1'b1;
              end else begin
                ctl_next.phase        = PH_SIZE;
                ctl_next.digit_seen   = 1'b0;
                ctl_next.in_extension = 1'b0;
                size_accum_next       = '0;
              end
            end
          end

          PH_IDLE: begin
            // bytes outside a body are dropped
          end

          default: ctl_next.phase = PH_IDLE;
        endcase
      end

      default: begin
        // unused kind code, dropped
      end
    endcase
  end

endmodule

>>> rtl/http_chunked_body_deframer.sv
// Top level of the HTTP request body deframer: beat registers, state and config.
// Takes one body beat per clock, unless the result register is stalled, and
// hands on payload bytes. A start beat picks fixed-length framing (count down
// body_length) or chunked framing (hex size lines, data, two dropped separator
// bytes, a zero-size chunk ends the body). Sustained rate is one beat per cycle
// while out_ready is high; each beat passes through the input register, where
// the whole state update is done in one pass, and then the result register.
// The longest path is the size-plus-running-total add and the limit compare at
// the end of a size line. Beats that cause no result (start, size line text,
// separators) leave nothing on the output. Config writes are taken every cycle
// and must only happen while the block is idle.
module http_chunked_body_deframer import cbd_pkg::*; #(
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  // config writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int LEFT_BITS = (SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W;

  // config registers
  logic [LIMIT_W-1:0] body_limit;
  logic               limit_enable;

  // input register
  in_t  in_q;
  logic in_q_valid;

  // parser state
  ctl_t                  ctl;
  logic [LEFT_BITS-1:0]  bytes_left;
  logic [SIZE_BITS-1:0]  size_accum;
  logic [TOTAL_BITS:0]   body_total;

  ctl_t                  ctl_next;
  logic [LEFT_BITS-1:0]  bytes_left_next;
  logic [SIZE_BITS-1:0]  size_accum_next;
  logic [TOTAL_BITS:0]   body_total_next;
  logic                  res_valid;
  out_t                  res;

  logic proc_fire;

  // the held beat is worked on once the result register has room
  assign proc_fire = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || proc_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit   <= BODY_LIMIT_RST;
      limit_enable <= LIMIT_EN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BODY_LIMIT:   body_limit   <= cfg_data;
        CFG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  cbd_step #(
    .SIZE_BITS  (SIZE_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_step (
    .item            (in_q),
    .body_limit      (body_limit),
    .limit_enable    (limit_enable),
    .ctl             (ctl),
    .bytes_left      (bytes_left),
    .size_accum      (size_accum),
    .body_total      (body_total),
    .ctl_next        (ctl_next),
    .bytes_left_next (bytes_left_next),
    .size_accum_next (size_accum_next),
    .body_total_next (body_total_next),
    .res_valid       (res_valid),
    .res             (res)
  );

  // parser state advances once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase           <= PH_IDLE;
      ctl.digit_seen      <= 1'b0;
      ctl.in_extension    <= 1'b0;
      ctl.last_chunk_seen <= 1'b0;
      ctl.skip_count      <= 2'd0;
      bytes_left          <= '0;
      size_accum          <= '0;
      body_total          <= '0;
    end else if (proc_fire) begin
      ctl        <= ctl_next;
      bytes_left <= bytes_left_next;
      size_accum <= size_accum_next;
      body_total <= body_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // a new result only appears after a beat was processed
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc_fire))
    else $error("result appeared without a processed beat");

  // non-payload results always close the body and carry a zero byte
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_PAYLOAD) |->
      (out_data.end_of_body && out_data.payload_byte == 8'd0))
    else $error("status result without end of body");

  // input stalls only when both registers are full and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_q_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  // data phases never sit with an exhausted count
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (ctl.phase == PH_DATA || ctl.phase == PH_FIXED) |-> (bytes_left != '0))
    else $error("data phase with zero bytes left");
`endif

endmodule

>>> tb/tb_http_chunked_body_deframer.sv
// Self-checking testbench for the HTTP chunked/fixed-length body deframer.
`timescale 1ns / 100ps

module tb_http_chunked_body_deframer;
  import cbd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;     // receiver hold-off, in cycles
  localparam int HOLD_AT     = 40;      // result count that starts the hold-off
  localparam int SETTLE      = 8;       // margin after the last result has come back

  localparam logic [1:0] KIND_UNUSED = 2'd3;   // no meaning, dropped by the block
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] BLANKS [5]  = '{CH_SP, CH_HT, CH_LF, CH_VT, CH_FF};

  localparam longint unsigned SIZE_CAP  = (64'd1 << 40) - 1;  // 40-bit chunk size
  localparam longint unsigned TOTAL_CAP = (64'd1 << 33) - 1;  // running total saturates

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  http_chunked_body_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deframer predictor: mirrors the block's state and its two config registers.
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] lim    = BODY_LIMIT_RST;
  logic               lim_en = LIMIT_EN_RST;

  phase_t      ph        = PH_IDLE;
  logic [39:0] left      = '0;   // bytes still owed in the current chunk/body
  logic [39:0] acc       = '0;   // size line being parsed
  logic        got_digit = 1'b0;
  logic        in_ext    = 1'b0;
  logic        last_seen = 1'b0; // zero-size chunk parsed, body ends after separator
  logic [1:0]  skip      = '0;
  logic [32:0] total     = '0;   // bytes of accepted chunks so far

  function automatic bit fail_with(input logic [1:0] st, output out_t r);
    ph            = PH_IDLE;
    r.payload_byte = 8'h00;
    r.status       = st;
    r.end_of_body  = 1'b1;
    return 1'b1;
  endfunction

  function automatic void start_line();
    ph        = PH_SIZE;
    acc       = '0;
    got_digit = 1'b0;
    in_ext    = 1'b0;
  endfunction

  // One character of a size line (phase SIZE or TRAIL).
  function automatic bit size_char(input logic [7:0] b, output out_t r);
    int dv;
    r = '0;
    if (b == CH_CR) begin
      ph = PH_CR;
      return 1'b0;
    end
    if (in_ext) return 1'b0;
    if (b == CH_SEMI) begin
      in_ext = 1'b1;
      return 1'b0;
    end
    if (b == CH_SP || (b >= CH_HT && b <= CH_FF)) begin
      if (got_digit) ph = PH_TRAIL;   // blanks after digits close the number
      return 1'b0;
    end
    if (b >= 8'h30 && b <= 8'h39)      dv = int'(b) - 'h30;
    else if (b >= 8'h41 && b <= 8'h46) dv = int'(b) - 'h41 + 10;
    else if (b >= 8'h61 && b <= 8'h66) dv = int'(b) - 'h61 + 10;
    else                               dv = -1;
    if (dv < 0 || ph == PH_TRAIL) return fail_with(ST_MALFORMED, r);
    if (longint'(acc) > (SIZE_CAP >> 4)) return fail_with(ST_MALFORMED, r);
    acc       = {acc[35:0], dv[3:0]};
    got_digit = 1'b1;
    return 1'b0;
  endfunction

  // CR LF seen: accept the chunk size, or end / fault the body.
  function automatic bit size_done(output out_t r);
    longint unsigned a, t;
    r = '0;
    if (!got_digit) return fail_with(ST_MALFORMED, r);
    if (acc == '0) begin
      last_seen = 1'b1;
      skip      = SKIP_LEN;
      ph        = PH_SKIP;
      return 1'b0;
    end
    a = 64'(acc);
    t = 64'(total);
    if (lim_en && (a > 64'(lim) || t > longint'(lim) - a)) return fail_with(ST_TOO_LARGE, r);
    if (a > TOTAL_CAP || t > TOTAL_CAP - a) total = TOTAL_CAP[32:0];
    else                                     total = 33'(t + a);
    left = acc;
    acc  = '0;
    ph   = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit deframe_step(input in_t it, output out_t r);
    logic [7:0] b;
    b = it.data_byte;
    r = '0;
    case (it.kind)
      KIND_CHUNKED: begin
        left      = '0;
        last_seen = 1'b0;
        skip      = '0;
        total     = '0;
        start_line();
        return 1'b0;
      end
      KIND_FIXED: begin
        acc       = '0;
        got_digit = 1'b0;
        in_ext    = 1'b0;
        last_seen = 1'b0;
        skip      = '0;
        total     = '0;
        left      = '0;
        if (lim_en && it.body_length > lim) return fail_with(ST_TOO_LARGE, r);
        if (it.body_length == '0) return fail_with(ST_EMPTY_END, r);
        left = 40'(it.body_length);
        ph   = PH_FIXED;
        return 1'b0;
      end
      KIND_BYTE: begin
        case (ph) inside
          PH_FIXED: begin
            left           = left - 40'd1;
            r.payload_byte = b;
            r.status       = ST_PAYLOAD;
            r.end_of_body  = (left == '0);
            if (left == '0) ph = PH_IDLE;
            return 1'b1;
          end
          PH_SIZE, PH_TRAIL: return size_char(b, r);
          PH_CR: begin
            if (b == CH_LF) return size_done(r);
            // lone CR counts as a blank
            ph = (got_digit && !in_ext) ? PH_TRAIL : PH_SIZE;
            return size_char(b, r);
          end
          PH_DATA: begin
            if (left != '0) left = left - 40'd1;
            if (left == '0) begin
              skip = SKIP_LEN;
              ph   = PH_SKIP;
            end
            r.payload_byte = b;
            r.status       = ST_PAYLOAD;
            r.end_of_body  = 1'b0;
            return 1'b1;
          end
          PH_SKIP: begin
            if (skip != '0) skip = skip - 2'd1;
            if (skip != '0) return 1'b0;
            if (last_seen) return fail_with(ST_EMPTY_END, r);
            start_line();
            return 1'b0;
          end
          default: begin
            ph = PH_IDLE;   // bytes while idle are dropped
            return 1'b0;
          end
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: fill the queue of input beats.
  // ---------------------------------------------------------------------------
  in_t  tx_beats[$];        // beats waiting for the driver
  out_t predicted_out[$];   // results owed by the block, oldest first
  int   pushed_n   = 0;
  int   accepted_n = 0;
  int   rx_n       = 0;
  int   mismatches = 0;
  bit   idle_on    = 1'b1;

  function automatic void push_beat(input logic [1:0] k, input logic [7:0] d,
                                    input logic [31:0] len);
    in_t b;
    b.kind        = k;
    b.data_byte   = d;
    b.body_length = len;
    tx_beats.push_back(b);
    pushed_n++;
  endfunction

  function automatic void push_byte(input logic [7:0] d);
    push_beat(KIND_BYTE, d, $urandom());
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
    if (d < 4'd10) return CH_ZERO + 8'(d);
    return (upper ? 8'h41 : 8'h61) + 8'(d - 4'd10);
  endfunction

  function automatic void push_separator();
    if ($urandom_range(0, 3) == 0) begin
      push_byte(rand_byte());   // not checked by the block
      push_byte(rand_byte());
    end else begin
      push_byte(CH_CR);
      push_byte(CH_LF);
    end
  endfunction

  // Size line for sz, optionally with blanks, leading zeros and an extension.
  function automatic void add_size_line(input logic [39:0] sz, input bit messy);
    logic [7:0]  digs[$];
    logic [39:0] v;
    logic [7:0]  x;
    bit          upper;
    v     = sz;
    upper = 1'($urandom_range(0, 1));
    do begin
      digs.push_front(hex_char(v[3:0], upper));
      v = v >> 4;
    end while (v != '0);
    if (messy) begin
      repeat ($urandom_range(0, 2)) push_byte(BLANKS[3'($urandom_range(0, 4))]);
      if ($urandom_range(0, 3) == 0) begin
        push_byte(CH_CR);   // CR not followed by LF is just a blank
        push_byte(CH_SP);
      end
      repeat ($urandom_range(0, 2)) push_byte(CH_ZERO);
    end
    foreach (digs[i]) push_byte(digs[i]);
    if (messy) begin
      repeat ($urandom_range(0, 1)) push_byte(BLANKS[3'($urandom_range(0, 1))]);
      if ($urandom_range(0, 2) == 0) begin
        push_byte(CH_SEMI);
        repeat ($urandom_range(0, 3)) begin
          x = rand_byte();
          push_byte(x == CH_CR ? CH_SEMI : x);
        end
      end
    end
    push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  // Chunked body of nchunks data chunks; fault 0 to 3 replaces the closing size
  // line by a broken one, any other fault value ends it with the zero chunk.
  function automatic void add_chunked(input int nchunks, input int maxsz, input int fault);
    int sz;
    push_beat(KIND_CHUNKED, rand_byte(), $urandom());
    repeat (nchunks) begin
      sz = $urandom_range(1, maxsz);
      add_size_line(40'(sz), 1'($urandom_range(0, 1)));
      repeat (sz) push_byte(rand_byte());
      push_separator();
    end
    case (fault)
      0: begin   // character that is not a hex digit
        repeat ($urandom_range(0, 2)) push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
        push_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h67, 8'h7E))
                                       : 8'($urandom_range(8'h80, 8'hFF)));
      end
      1: begin   // digit after a blank that followed a digit
        push_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
        push_byte(BLANKS[3'($urandom_range(0, 1))]);
        push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
      end
      2: begin   // no digits before CR LF
        repeat ($urandom_range(0, 2)) push_byte(CH_SP);
        if ($urandom_range(0, 1)) begin
          push_byte(CH_SEMI);
          push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
        end
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      3: begin   // eleven significant digits overflow the size
        push_byte(hex_char(4'($urandom_range(1, 15)), 1'b1));
        repeat (10) push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      default: begin
        add_size_line('0, 1'($urandom_range(0, 1)));
        push_separator();
      end
    endcase
  endfunction

  // Random mix; mostly well-formed bodies, then faults, abandoned and noise beats.
  function automatic void add_random(input int n);
    int stop, pick, len;
    stop = pushed_n + n;
    while (pushed_n < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        add_chunked($urandom_range(0, 3), 12, -1);
      end else if (pick < 65) begin
        len = $urandom_range(0, 12);
        push_beat(KIND_FIXED, rand_byte(), 32'(len));
        repeat (len) push_byte(rand_byte());
      end else if (pick < 80) begin
        add_chunked($urandom_range(0, 2), 6, $urandom_range(0, 3));
      end else if (pick < 88) begin
        // huge body, abandoned by the next start
        if ($urandom_range(0, 1)) begin
          push_beat(KIND_FIXED, rand_byte(), $urandom());
        end else begin
          push_beat(KIND_CHUNKED, rand_byte(), $urandom());
          add_size_line({8'($urandom_range(1, 255)), 32'($urandom())}, 1'b0);
        end
        repeat ($urandom_range(0, 4)) push_byte(rand_byte());
      end else if (pick < 94) begin
        // truncated fixed body, cut off by the next start
        push_beat(KIND_FIXED, rand_byte(), $urandom_range(4, 12));
        repeat ($urandom_range(1, 3)) push_byte(rand_byte());
      end else begin
        repeat ($urandom_range(1, 3))
          push_beat($urandom_range(0, 1) ? KIND_BYTE : KIND_UNUSED, rand_byte(), $urandom());
      end
    end
    push_beat(KIND_FIXED, rand_byte(), '0);   // leave the block idle
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one beat per handshake, random idle bursts between beats.
  // ---------------------------------------------------------------------------
  logic drv_valid;
  in_t  drv_next;
  out_t guess;
  int   tx_gap  = 0;
  int   tx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drv_valid = in_valid;
      if (in_valid && in_ready) begin
        accepted_n++;
        if (deframe_step(in_data, guess)) predicted_out.push_back(guess);
        drv_valid = 1'b0;
      end
      if (!drv_valid && tx_beats.size() != 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (idle_on && tx_calm == 0 && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 10);
        end else begin
          drv_next  = tx_beats.pop_front();
          drv_valid = 1'b1;
          in_data  <= drv_next;
          if (tx_calm > 0) tx_calm--;
          else if ($urandom_range(0, 31) == 0) tx_calm = $urandom_range(20, 60);
        end
      end
      in_valid <= drv_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each result beat against the oldest prediction and
  // throttles out_ready, with one long hold-off to back up the block.
  // ---------------------------------------------------------------------------
  out_t want;
  logic rx_ready;
  int   rx_gap    = 0;
  int   rx_calm   = 0;
  int   hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_n++;
        if (rx_n == HOLD_AT) hold_left = LONG_HOLD;
        if (predicted_out.size() == 0) begin
          $error("result beat with nothing predicted: payload_byte %0h status %0d end %0b",
                 out_data.payload_byte, out_data.status, out_data.end_of_body);
          mismatches++;
        end else begin
          want = predicted_out.pop_front();
          if (out_data.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                   out_data.payload_byte);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.end_of_body !== want.end_of_body) begin
            $error("end_of_body: expected %0b, got %0b", want.end_of_body,
                   out_data.end_of_body);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else if (!idle_on || rx_calm > 0) begin
        if (rx_calm > 0) rx_calm--;
        rx_ready = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rx_ready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        rx_gap   = $urandom_range(0, 10);
        rx_ready = 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) rx_calm = $urandom_range(20, 60);
        rx_ready = 1'b1;
      end
      out_ready <= rx_ready;
    end
  end

  // Watchdog.
  int cycle_n = 0;

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed beats, then random phases under several configs.
  // ---------------------------------------------------------------------------

  // Register write; only issued while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BODY_LIMIT) lim = val;
    else if (idx == CFG_LIMIT_ENABLE) lim_en = val[0];
  endtask

  // Sender pauses until every beat is taken and every result is back.
  task automatic settle();
    while (accepted_n != pushed_n || predicted_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset config (1 MiB limit, enforced).
    push_beat(KIND_FIXED, 8'h00, 32'h0);           // empty fixed body
    push_beat(KIND_FIXED, 8'hFF, 32'hFFFF_FFFF);   // declared length over limit
    push_beat(KIND_FIXED, 8'h00, 32'h1);
    push_byte(8'hFF);                              // last fixed byte carries end
    push_byte(8'h5A);                              // idle byte, dropped
    push_beat(KIND_UNUSED, 8'hA5, 32'h1234_5678);  // dropped kind
    push_beat(KIND_CHUNKED, 8'h00, 32'h0);         // lone CR and blank before digit
    push_byte(CH_CR);
    push_byte(CH_SP);
    push_byte(hex_char(4'h1, 1'b0));
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'h00);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_ZERO);                            // last chunk
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_beat(KIND_FIXED, 8'h00, 32'h3);           // abandoned by the next start
    push_byte(8'h81);
    push_beat(KIND_CHUNKED, 8'h00, 32'h0);         // 0x200000 is over the limit
    push_byte(hex_char(4'h2, 1'b0));
    repeat (5) push_byte(CH_ZERO);
    push_byte(CH_CR);
    push_byte(CH_LF);
    settle();

    // Streaming upload: no limit.
    write_reg(CFG_BODY_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_LIMIT_ENABLE, 32'd0);
    add_random(100);
    settle();

    // Zero limit: every non-empty body is too large.
    write_reg(CFG_BODY_LIMIT, 32'h0);
    write_reg(CFG_LIMIT_ENABLE, 32'd1);
    add_random(60);
    settle();

    // Small limit, so the running total of chunks trips it now and then.
    write_reg(CFG_BODY_LIMIT, $urandom_range(20, 60));
    add_random(120);
    settle();

    // Widest limit, and no idling on either side to the end.
    write_reg(CFG_BODY_LIMIT, 32'hFFFF_FFFF);
    @(posedge clk);
    idle_on <= 1'b0;
    add_random(120);
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cbd_pkg.sv
rtl/cbd_step.sv
rtl/http_chunked_body_deframer.sv
tb/tb_http_chunked_body_deframer.sv
